// ----- rtl/core/rtc_pkg.sv -----
// Shared types for the rigid transform chain: controller commands and status.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package rtc_pkg;

	// Action codes of an input transaction
	localparam logic [1:0] ACT_FORWARD = 2'd0;
	localparam logic [1:0] ACT_INVERSE = 2'd1;
	localparam logic [1:0] ACT_LOAD    = 2'd2;

	// Fixed field widths
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned STEPS_W = 4;
	localparam int unsigned COORD_FRAC = 8;

	// Controller to datapath commands
	typedef struct packed {
		logic       start;     // latch point, clear flags
		logic       inverse;   // direction, sampled with start
		logic       applied;   // any entries in use, sampled with start
		logic       wr_en;     // write table entry from input fields
		logic       rd_en;     // read table entry
		logic       sub_t;     // p <= clip(p - t)
		logic       mul_en;    // products for column mul_sel
		logic [1:0] mul_sel;
		logic       acc_clr;
		logic       acc_en;
		logic       round_en;  // p <= clip(round(acc))
		logic       add_t;     // p <= clip(p + t)
		logic       out_load;
	} rtc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} rtc_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/rigid_transform_chain_top.sv -----
// Rigid transform chain top level: controller and datapath.
// Depends on rtc_pkg, rtc_ctrl, rtc_datapath and rtc_ram.
//
// Usage:
//   Input channel (in_valid/in_stall): action 0 carries a point forward
//   through entries 0..n-1 (p = M*p + t), action 1 carries it back through
//   entries n-1..0 (p = M^T*(p - t)), action 2 loads entry entry_index with
//   three matrix rows and a translation. Action 3 is dropped.
//   Configuration channel (cfg_valid/cfg_ready): steps_in_use sets n;
//   write it only while the block is idle. Values above TABLE_DEPTH apply
//   TABLE_DEPTH entries.
//   Output channel (out_valid/out_stall): one result per point transaction,
//   none for loads. With n = 0 the point is echoed with applied low.
// Sequence: a load is written in the idle state. Each entry costs a table
//   read, a prepare step (the pre-subtract for inverse points), three
//   multiply steps and one accumulate step on a shared set of three
//   multipliers, a rounding step and, forward only, a translate step.
//   The input stalls while a point is processed and until its result is
//   loaded, so one point is in the chain at a time; loads do not stall it.
// Reset clears the step count to 0 and empties the result register; table
//   contents are undefined until loaded. A stalled result holds while the
//   next point is already being processed; the block waits at completion
//   only if the result register is still occupied.
`default_nettype none

module rigid_transform_chain_top #(
	parameter int unsigned TABLE_DEPTH = 8,
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned COEF_WIDTH  = 18
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    action,
	input  wire logic signed [COORD_WIDTH-1:0] x_coord,
	input  wire logic signed [COORD_WIDTH-1:0] y_coord,
	input  wire logic signed [COORD_WIDTH-1:0] z_coord,
	input  wire logic [rtc_pkg::INDEX_W-1:0]   entry_index,
	input  wire logic [3*COEF_WIDTH-1:0]       row_first,
	input  wire logic [3*COEF_WIDTH-1:0]       row_second,
	input  wire logic [3*COEF_WIDTH-1:0]       row_third,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rtc_pkg::STEPS_W-1:0]   steps_in_use,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0]      x_out,
	output logic signed [COORD_WIDTH-1:0]      y_out,
	output logic signed [COORD_WIDTH-1:0]      z_out,
	output logic                               saturated,
	output logic                               applied
);
	import rtc_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	rtc_cmd_t    cmd;
	rtc_status_t status;
	logic [AW-1:0] wr_addr, rd_addr;

	rtc_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.entry_index (entry_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.steps_in_use(steps_in_use),
		.status      (status),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr)
	);

	rtc_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COORD_WIDTH(COORD_WIDTH),
		.COEF_WIDTH (COEF_WIDTH),
		.AW         (AW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.z_coord   (z_coord),
		.row_first (row_first),
		.row_second(row_second),
		.row_third (row_third),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.x_out     (x_out),
		.y_out     (y_out),
		.z_out     (z_out),
		.saturated (saturated),
		.applied   (applied)
	);

endmodule

`default_nettype wire

// ----- rtl/core/rtc_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module rtc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; read data holds between reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rtc_ctrl.sv -----
// Controller of the rigid transform chain: sequences table reads and the
// multiply, round and translate steps per entry. Depends on rtc_pkg.
`default_nettype none

module rtc_ctrl #(
	parameter int unsigned TABLE_DEPTH = 8,
	parameter int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 action,
	input  wire logic [rtc_pkg::INDEX_W-1:0] entry_index,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [rtc_pkg::STEPS_W-1:0] steps_in_use,
	input  wire rtc_pkg::rtc_status_t       status,
	output rtc_pkg::rtc_cmd_t               cmd,
	output logic [AW-1:0]                   wr_addr,
	output logic [AW-1:0]                   rd_addr
);
	import rtc_pkg::*;

	localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_READ = 10'b0000000010,
		ST_PREP = 10'b0000000100,
		ST_MUL0 = 10'b0000001000,
		ST_MUL1 = 10'b0000010000,
		ST_MUL2 = 10'b0000100000,
		ST_ACC  = 10'b0001000000,
		ST_RND  = 10'b0010000000,
		ST_ADD  = 10'b0100000000,
		ST_FIN  = 10'b1000000000
	} state_t;

	state_t            state_q, state_d;
	logic [STEPS_W-1:0] steps_q;
	logic [CNTW-1:0]   cnt_q;
	logic [AW-1:0]     entry_q;
	logic              inverse_q;
	logic [6:0]        n_sel;
	logic [6:0]        idx_w;
	logic              accept;
	logic              is_point;
	logic              last;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign is_point  = (action == ACT_FORWARD) || (action == ACT_INVERSE);
	assign n_sel     = (7'(steps_q) > 7'(TABLE_DEPTH)) ? 7'(TABLE_DEPTH) : 7'(steps_q);
	assign idx_w     = 7'(entry_index);
	assign wr_addr   = idx_w[AW-1:0];
	assign rd_addr   = entry_q;
	assign last      = (cnt_q == CNTW'(1));

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			steps_q <= steps_in_use;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.inverse = (action == ACT_INVERSE);
		cmd.applied = (n_sel != 7'd0);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_LOAD) begin
					cmd.wr_en = (idx_w < 7'(TABLE_DEPTH));
				end else if (accept && is_point) begin
					cmd.start = 1'b1;
					state_d   = (n_sel == 7'd0) ? ST_FIN : ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_PREP;
			end
			ST_PREP: begin
				cmd.sub_t = inverse_q;
				state_d   = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = 2'd0;
				cmd.acc_clr = 1'b1;
				state_d     = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = 2'd1;
				cmd.acc_en  = 1'b1;
				state_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = 2'd2;
				cmd.acc_en  = 1'b1;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = ST_RND;
			end
			ST_RND: begin
				cmd.round_en = 1'b1;
				if (!inverse_q) begin
					state_d = ST_ADD;
				end else begin
					state_d = last ? ST_FIN : ST_READ;
				end
			end
			ST_ADD: begin
				cmd.add_t = 1'b1;
				state_d   = last ? ST_FIN : ST_READ;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, entry pointer and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			entry_q   <= '0;
			inverse_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				inverse_q <= cmd.inverse;
				cnt_q     <= n_sel[CNTW-1:0];
				entry_q   <= cmd.inverse ? AW'(n_sel - 7'd1) : '0;
			end else if ((cmd.add_t || (cmd.round_en && inverse_q)) && !last) begin
				cnt_q   <= cnt_q - CNTW'(1);
				entry_q <= inverse_q ? entry_q - AW'(1) : entry_q + AW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rtc_datapath.sv -----
// Datapath of the rigid transform chain: table RAM, point registers, three
// multiply-accumulate lanes, rounding, clipping and the result register.
// Depends on rtc_pkg and rtc_ram.
`default_nettype none

module rtc_datapath #(
	parameter int unsigned TABLE_DEPTH = 8,
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned COEF_WIDTH  = 18,
	parameter int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rtc_pkg::rtc_cmd_t             cmd,
	output rtc_pkg::rtc_status_t               status,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [AW-1:0]                 rd_addr,
	input  wire logic signed [COORD_WIDTH-1:0] x_coord,
	input  wire logic signed [COORD_WIDTH-1:0] y_coord,
	input  wire logic signed [COORD_WIDTH-1:0] z_coord,
	input  wire logic [3*COEF_WIDTH-1:0]       row_first,
	input  wire logic [3*COEF_WIDTH-1:0]       row_second,
	input  wire logic [3*COEF_WIDTH-1:0]       row_third,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0]      x_out,
	output logic signed [COORD_WIDTH-1:0]      y_out,
	output logic signed [COORD_WIDTH-1:0]      z_out,
	output logic                               saturated,
	output logic                               applied
);
	import rtc_pkg::*;

	localparam int unsigned CW    = COORD_WIDTH;
	localparam int unsigned KW    = COEF_WIDTH;
	localparam int unsigned CF    = COEF_WIDTH - 2;
	localparam int unsigned RW    = 3 * KW;
	localparam int unsigned EW    = 3 * RW + 3 * CW;
	localparam int unsigned PW    = KW + CW;
	localparam int unsigned ACCW  = PW + 2;
	localparam int unsigned SHW   = ACCW - CF;
	localparam logic signed [ACCW-1:0] HALF = ACCW'(1) <<< (CF - 1);
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic [EW-1:0]          wr_data, rd_data;
	logic [RW-1:0]          rows [3];
	logic signed [CW-1:0]   tv [3];
	logic signed [CW-1:0]   p_q [3];
	logic signed [PW-1:0]   prod_s1 [3];
	logic signed [ACCW-1:0] acc_q [3];
	logic signed [KW-1:0]   coef_sel [3];
	logic signed [ACCW-1:0] rnd [3];
	logic signed [SHW-1:0]  shv [3];
	logic signed [CW:0]     sum_t [3];
	logic signed [CW-1:0]   rnd_clip [3];
	logic signed [CW-1:0]   sum_clip [3];
	logic [2:0]             rnd_ovf, sum_ovf;
	logic                   inverse_q, sat_q, applied_q;

	// Table entry: translation over the three rows
	assign wr_data = {z_coord, y_coord, x_coord, row_third, row_second, row_first};

	rtc_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Unpack entry, select coefficients, round and clip per lane
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rows[r] = rd_data[r*RW +: RW];
			tv[r]   = $signed(rd_data[3*RW + r*CW +: CW]);
		end
		for (int r = 0; r < 3; r++) begin
			// forward uses row r, inverse uses column r (transpose)
			coef_sel[r] = inverse_q ? $signed(rows[cmd.mul_sel][r*KW +: KW])
			                        : $signed(rows[r][cmd.mul_sel*KW +: KW]);
			rnd[r] = acc_q[r] + HALF;
			shv[r] = SHW'(rnd[r] >>> CF);
			rnd_ovf[r] = (shv[r][SHW-1:CW-1] != {(SHW-CW+1){shv[r][SHW-1]}});
			rnd_clip[r] = rnd_ovf[r] ? (shv[r][SHW-1] ? CMIN : CMAX) : shv[r][CW-1:0];
			sum_t[r] = cmd.sub_t ? ((CW+1)'(p_q[r]) - (CW+1)'(tv[r]))
			                     : ((CW+1)'(p_q[r]) + (CW+1)'(tv[r]));
			sum_ovf[r] = (sum_t[r][CW] != sum_t[r][CW-1]);
			sum_clip[r] = sum_ovf[r] ? (sum_t[r][CW] ? CMIN : CMAX) : sum_t[r][CW-1:0];
		end
	end

	// Point, products and accumulators
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			p_q[0] <= x_coord;
			p_q[1] <= y_coord;
			p_q[2] <= z_coord;
		end
		for (int r = 0; r < 3; r++) begin
			if (cmd.mul_en) begin
				prod_s1[r] <= PW'(coef_sel[r]) * PW'(p_q[cmd.mul_sel]);
			end
			if (cmd.acc_clr) begin
				acc_q[r] <= '0;
			end else if (cmd.acc_en) begin
				acc_q[r] <= acc_q[r] + ACCW'(prod_s1[r]);
			end
			if (cmd.round_en) begin
				p_q[r] <= rnd_clip[r];
			end else if (cmd.sub_t || cmd.add_t) begin
				p_q[r] <= sum_clip[r];
			end
		end
	end

	// Transaction flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
			sat_q     <= 1'b0;
			applied_q <= 1'b0;
		end else if (cmd.start) begin
			inverse_q <= cmd.inverse;
			sat_q     <= 1'b0;
			applied_q <= cmd.applied;
		end else if (cmd.round_en && (rnd_ovf != 3'b000)) begin
			sat_q <= 1'b1;
		end else if ((cmd.sub_t || cmd.add_t) && (sum_ovf != 3'b000)) begin
			sat_q <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			x_out     <= p_q[0];
			y_out     <= p_q[1];
			z_out     <= p_q[2];
			saturated <= sat_q;
			applied   <= applied_q;
		end
	end

	assign status.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ----- rtl/core/rtc_checker.sv -----
// Port-level checker for the rigid transform chain, bound to the top level.
// Depends on rigid_transform_chain_top.
`default_nettype none

module rtc_checker #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [COORD_WIDTH-1:0] x_out,
	input wire logic                   saturated,
	input wire logic                   applied
);

	// A stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its x coordinate
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(x_out))
		else $error("result changed while stalled");

	// A new result follows a busy cycle of the input side
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a processed transaction");

	// An echoed point never reports clipping
	a_echo_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !applied |-> !saturated)
		else $error("saturation reported on echoed point");

endmodule

bind rigid_transform_chain_top rtc_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_rtc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.x_out    (x_out),
	.saturated(saturated),
	.applied  (applied)
);

`default_nettype wire
